>>> src/tsc_pkg.sv
// tsc_pkg.sv: shared widths, angle constants, series coefficients and the lane type
// of the Taylor sine/cosine pipeline. No dependencies.
`default_nettype none

package tsc_pkg;

	localparam int ANGLE_W    = 32;
	localparam int OUT_W      = 32;
	localparam int ANGLE_FRAC = 20;
	localparam int Q_FRAC     = 30;
	localparam int MAG_W      = 32;
	localparam int REM_W      = 23;
	localparam int REM0_W     = REM_W + 1;
	localparam int Q_W        = 10;
	localparam int RECIP_W    = 20;
	localparam int RECIP_SH   = 42;
	localparam int X_W        = 21;
	localparam int X30_W      = X_W + Q_FRAC - ANGLE_FRAC;
	localparam int SQ_W       = 32;
	localparam int P_W        = 42;
	localparam int P_SPLIT    = P_W / 2;
	localparam int TERM_W     = 31;
	localparam int ACC_W      = 34;
	localparam int COEF_W     = 64;
	localparam int COEF_SPLIT = COEF_W / 2;
	localparam int MAX_TERMS  = 8;

	localparam logic [REM_W-1:0] TWO_PI_Q        = 23'd6588397;
	localparam logic [REM_W-1:0] THREE_HALF_PI_Q = 23'd4941298;
	localparam logic [REM_W-1:0] PI_Q            = 23'd3294199;
	localparam logic [REM_W-1:0] HALF_PI_Q       = 23'd1647099;
	localparam logic [OUT_W-1:0] ONE_Q30         = 32'h4000_0000;

	// floor(2^RECIP_SH / 2pi), quotient estimate is low by at most one
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(TWO_PI_Q));

	// 1/(2k+1)! as unsigned Q0.64, k = 1..8
	localparam logic [COEF_W-1:0] INV_FACT [MAX_TERMS] = '{
		64'd3074457345618258603,
		64'd153722867280912930,
		64'd3660068268593165,
		64'd50834281508238,
		64'd462129831893,
		64'd2962370717,
		64'd14106527,
		64'd51862
	};

	typedef struct packed {
		logic                     valid;
		logic                     neg;
		logic [P_W-1:0]           p;
		logic [SQ_W-1:0]          sq;
		logic signed [ACC_W-1:0]  acc;
		logic [TERM_W-1:0]        term;
	} tsc_lane_t;

endpackage

`default_nettype wire

>>> src/tsc_reduce.sv
// tsc_reduce.sv: six-stage front end: cosine offset, modulo 2pi by reciprocal, fold
// to [0, pi/2], square of the folded angle. Depends on tsc_pkg.
`default_nettype none

module tsc_reduce import tsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               run,
	input  logic               in_valid,
	input  logic [ANGLE_W-1:0] angle_in,
	input  logic               operation,
	output tsc_lane_t          lane
);

	logic [ANGLE_W:0]           a_sum;
	logic [ANGLE_W:0]           a_abs;
	logic                       a_neg;
	logic [MAG_W+RECIP_W-1:0]   quo_prod;
	logic [MAG_W:0]             sub_prod;
	logic [MAG_W:0]             rem0;
	logic [X_W-1:0]             x_fold;
	logic                       flip;
	logic [X30_W-1:0]           x30;
	logic [2*X30_W-1:0]         sq_prod;

	logic                       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MAG_W-1:0]           mag_s1, mag_s2;
	logic [Q_W-1:0]             q_s2;
	logic [REM0_W-1:0]          rem0_s3;
	logic [REM_W-1:0]           rem_s4;
	logic [X_W-1:0]             x_s5;
	logic [X30_W-1:0]           x30_s6;
	logic [SQ_W-1:0]            sq_s6;

	assign a_sum = {angle_in[ANGLE_W-1], angle_in}
		+ {{(ANGLE_W+1-REM_W){1'b0}}, (operation ? HALF_PI_Q : {REM_W{1'b0}})};
	assign a_neg = a_sum[ANGLE_W];
	assign a_abs = a_neg ? (~a_sum + 1'b1) : a_sum;

	assign quo_prod = (MAG_W+RECIP_W)'(mag_s1) * (MAG_W+RECIP_W)'(RECIP);

	assign sub_prod = (MAG_W+1)'(q_s2) * (MAG_W+1)'(TWO_PI_Q);
	assign rem0     = (MAG_W+1)'(mag_s2) - sub_prod;

	always_comb begin
		flip   = 1'b0;
		x_fold = rem_s4[X_W-1:0];
		if (rem_s4 > THREE_HALF_PI_Q) begin
			x_fold = X_W'(TWO_PI_Q - rem_s4);
			flip   = 1'b1;
		end else if (rem_s4 > PI_Q) begin
			x_fold = X_W'(rem_s4 - PI_Q);
			flip   = 1'b1;
		end else if (rem_s4 > HALF_PI_Q) begin
			x_fold = X_W'(PI_Q - rem_s4);
		end
	end

	assign x30     = {x_s5, {(Q_FRAC-ANGLE_FRAC){1'b0}}};
	assign sq_prod = (2*X30_W)'(x30) * (2*X30_W)'(x30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (run) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			neg_s1  <= a_neg;
			mag_s1  <= a_abs[MAG_W-1:0];
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			q_s2    <= quo_prod[RECIP_SH +: Q_W];
			neg_s3  <= neg_s2;
			rem0_s3 <= rem0[REM0_W-1:0];
			neg_s4  <= neg_s3;
			rem_s4  <= (rem0_s3 >= REM0_W'(TWO_PI_Q)) ?
				REM_W'(rem0_s3 - REM0_W'(TWO_PI_Q)) : rem0_s3[REM_W-1:0];
			neg_s5  <= neg_s4 ^ flip;
			x_s5    <= x_fold;
			neg_s6  <= neg_s5;
			x30_s6  <= x30;
			sq_s6   <= sq_prod[Q_FRAC +: SQ_W];
		end
	end

	assign lane.valid = valid_s6;
	assign lane.neg   = neg_s6;
	assign lane.p     = P_W'(x30_s6);
	assign lane.sq    = sq_s6;
	assign lane.acc   = $signed(ACC_W'(x30_s6));
	assign lane.term  = '0;

endmodule

`default_nettype wire

>>> src/tsc_term.sv
// tsc_term.sv: one series term in four stages: next odd power, product with 1/(2k+1)!,
// and the signed add of the previous term. Depends on tsc_pkg.
`default_nettype none

module tsc_term import tsc_pkg::*; #(
	parameter int TERM_IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run,
	input  tsc_lane_t lane_in,
	output tsc_lane_t lane_out
);

	localparam logic [COEF_W-1:0] COEF = INV_FACT[TERM_IDX];
	localparam bit PREV_ADD = (TERM_IDX % 2) == 0;
	localparam int PP_W   = P_SPLIT + SQ_W;
	localparam int PSUM_W = P_W + SQ_W;
	localparam int CP_W   = P_SPLIT + COEF_SPLIT;
	localparam int CSUM_W = P_W + COEF_W;

	logic signed [ACC_W-1:0] term_ext;
	logic signed [ACC_W-1:0] acc_next;
	logic [PP_W-1:0]         ppl, pph;
	logic [PSUM_W-1:0]       pwr_sum;
	logic [CP_W-1:0]         cll, clh, chl, chh;
	logic [CSUM_W-1:0]       tsum;

	logic                    valid_s1, valid_s2, valid_s3, valid_s4;
	logic                    neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SQ_W-1:0]         sq_s1, sq_s2, sq_s3, sq_s4;
	logic signed [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4;
	logic [PP_W-1:0]         ppl_s1, pph_s1;
	logic [P_W-1:0]          p_s2, p_s3, p_s4;
	logic [CP_W-1:0]         cll_s3, clh_s3, chl_s3, chh_s3;
	logic [TERM_W-1:0]       term_s4;

	assign term_ext = $signed({{(ACC_W-TERM_W){1'b0}}, lane_in.term});
	assign acc_next = PREV_ADD ? (lane_in.acc + term_ext) : (lane_in.acc - term_ext);

	assign ppl = PP_W'(lane_in.p[P_SPLIT-1:0]) * PP_W'(lane_in.sq);
	assign pph = PP_W'(lane_in.p[P_W-1:P_SPLIT]) * PP_W'(lane_in.sq);

	assign pwr_sum = PSUM_W'(ppl_s1) + (PSUM_W'(pph_s1) << P_SPLIT);

	assign cll = CP_W'(p_s2[P_SPLIT-1:0]) * CP_W'(COEF[COEF_SPLIT-1:0]);
	assign clh = CP_W'(p_s2[P_SPLIT-1:0]) * CP_W'(COEF[COEF_W-1:COEF_SPLIT]);
	assign chl = CP_W'(p_s2[P_W-1:P_SPLIT]) * CP_W'(COEF[COEF_SPLIT-1:0]);
	assign chh = CP_W'(p_s2[P_W-1:P_SPLIT]) * CP_W'(COEF[COEF_W-1:COEF_SPLIT]);

	assign tsum = CSUM_W'(cll_s3)
		+ (CSUM_W'(clh_s3) << COEF_SPLIT)
		+ (CSUM_W'(chl_s3) << P_SPLIT)
		+ (CSUM_W'(chh_s3) << (P_SPLIT + COEF_SPLIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (run) begin
			valid_s1 <= lane_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			neg_s1  <= lane_in.neg;
			sq_s1   <= lane_in.sq;
			acc_s1  <= acc_next;
			ppl_s1  <= ppl;
			pph_s1  <= pph;
			neg_s2  <= neg_s1;
			sq_s2   <= sq_s1;
			acc_s2  <= acc_s1;
			p_s2    <= pwr_sum[Q_FRAC +: P_W];
			neg_s3  <= neg_s2;
			sq_s3   <= sq_s2;
			acc_s3  <= acc_s2;
			p_s3    <= p_s2;
			cll_s3  <= cll;
			clh_s3  <= clh;
			chl_s3  <= chl;
			chh_s3  <= chh;
			neg_s4  <= neg_s3;
			sq_s4   <= sq_s3;
			acc_s4  <= acc_s3;
			p_s4    <= p_s3;
			term_s4 <= tsum[COEF_W +: TERM_W];
		end
	end

	assign lane_out.valid = valid_s4;
	assign lane_out.neg   = neg_s4;
	assign lane_out.p     = p_s4;
	assign lane_out.sq    = sq_s4;
	assign lane_out.acc   = acc_s4;
	assign lane_out.term  = term_s4;

endmodule

`default_nettype wire

>>> src/tsc_out.sv
// tsc_out.sv: last term add, saturation to +/-1 and sign, output register with skid
// stage; drives the pipeline advance. Depends on tsc_pkg.
`default_nettype none

module tsc_out import tsc_pkg::*; #(
	parameter int TERM_COUNT = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tsc_lane_t        lane_in,
	output logic             run,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam bit LAST_ADD = ((TERM_COUNT - 1) % 2) == 1;

	logic signed [ACC_W-1:0] term_ext;
	logic signed [ACC_W-1:0] acc_next;
	logic [OUT_W-1:0]        mag;
	logic [OUT_W-1:0]        result;

	logic                    valid_s1;
	logic                    neg_s1;
	logic signed [ACC_W-1:0] acc_s1;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic                    skid_valid_q;
	logic [OUT_W-1:0]        skid_data_q;

	assign term_ext = $signed({{(ACC_W-TERM_W){1'b0}}, lane_in.term});
	assign acc_next = LAST_ADD ? (lane_in.acc + term_ext) : (lane_in.acc - term_ext);

	always_comb begin
		if (acc_s1[ACC_W-1]) begin
			mag = '0;
		end else if (acc_s1 > $signed({{(ACC_W-OUT_W){1'b0}}, ONE_Q30})) begin
			mag = ONE_Q30;
		end else begin
			mag = acc_s1[OUT_W-1:0];
		end
		result = neg_s1 ? (~mag + 1'b1) : mag;
	end

	assign run = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (run) begin
				valid_s1 <= lane_in.valid;
			end
			if (skid_valid_q) begin
				if (m_tready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (valid_s1) begin
				if (out_valid_q && !m_tready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			neg_s1 <= lane_in.neg;
			acc_s1 <= acc_next;
		end
		if (skid_valid_q) begin
			if (m_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (valid_s1) begin
			if (out_valid_q && !m_tready) begin
				skid_data_q <= result;
			end else begin
				out_data_q <= result;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> src/taylor_sine_cosine.sv
// taylor_sine_cosine.sv: top level of the pipelined Taylor series sine/cosine unit.
// Depends on tsc_pkg, tsc_reduce, tsc_term and tsc_out.
//
// channel   direction  tdata                        tuser
// s_axis    in         [31:0] angle_in, Q12.20      [0] operation (0 sine, 1 cosine)
// m_axis    out        [31:0] trig_value, Q2.30     none
//
// One word per clock in and out while the skid stage is empty. A word passes through
// reduction, fold and square, then each series term, the last add and the output.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipe advances while the skid stage is empty; s_axis_tready is low while a
// word sits in the skid stage and returns when it drains.
`default_nettype none

module taylor_sine_cosine import tsc_pkg::*; #(
	parameter int TERM_COUNT = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [ANGLE_W-1:0] s_axis_tdata,   // [31:0] angle_in
	input  logic [0:0]         s_axis_tuser,   // [0] operation
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata    // [31:0] trig_value
);

	logic      run;
	tsc_lane_t lane [TERM_COUNT+1];

	assign s_axis_tready = run;

	tsc_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.in_valid  (s_axis_tvalid),
		.angle_in  (s_axis_tdata),
		.operation (s_axis_tuser[0]),
		.lane      (lane[0])
	);

	for (genvar i = 0; i < TERM_COUNT; i++) begin : g_term
		tsc_term #(
			.TERM_IDX (i)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.run      (run),
			.lane_in  (lane[i]),
			.lane_out (lane[i+1])
		);
	end

	tsc_out #(
		.TERM_COUNT (TERM_COUNT)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.lane_in  (lane[TERM_COUNT]),
		.run      (run),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> src/tsc_checker.sv
// tsc_checker.sv: port-level checks of taylor_sine_cosine, bound to the top level.
// Depends on tsc_pkg.
`default_nettype none

module tsc_checker import tsc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	logic [7:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 8'(s_axis_tvalid && s_axis_tready)
				- 8'(m_axis_tvalid && m_axis_tready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled without a waiting output word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed(ONE_Q30))
			&& ($signed(m_axis_tdata) >= -$signed(ONE_Q30)))
		else $error("result outside +/-1");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 8'd0)
		else $error("output word without an accepted input word");

endmodule

bind taylor_sine_cosine tsc_checker u_tsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/tb.sv
// tb.sv: self-checking testbench for taylor_sine_cosine, directed and random angles.
// Predicts each sine/cosine word in fixed point; depends only on tsc_pkg and the RTL.
module tb;
	import tsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SERIES_TERMS = 6;
	localparam int DRAIN_CYCLES = 6 + 4 * SERIES_TERMS + 2 + 10;

	localparam longint ANG_2PI  = 64'sd6588397;
	localparam longint ANG_3HPI = 64'sd4941298;
	localparam longint ANG_PI   = 64'sd3294199;
	localparam longint ANG_HPI  = 64'sd1647099;
	localparam longint UNIT_Q30 = 64'sd1073741824;

	typedef enum logic {
		OP_SINE   = 1'b0,
		OP_COSINE = 1'b1
	} trig_op_e;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [ANGLE_W-1:0] s_axis_tdata;   // [31:0] angle_in
	logic [0:0]         s_axis_tuser;   // [0] operation
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;   // [31:0] trig_value

	logic [OUT_W-1:0] trig_expected[$];
	int               send_idle_pct;
	int               sink_stall_pct;
	int               fail_count;
	int               words_checked;
	int               sine_sent;
	int               cosine_sent;

	taylor_sine_cosine #(
		.TERM_COUNT(SERIES_TERMS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("timeout: %0d words still expected", trig_expected.size());
		$display("DONE: errors detected");
		$finish;
	end

	// 1/(2k+3)! as Q0.64, k = 0..7
	function automatic logic [63:0] inv_factorial(int k);
		case (k)
			0: return 64'd3074457345618258603;
			1: return 64'd153722867280912930;
			2: return 64'd3660068268593165;
			3: return 64'd50834281508238;
			4: return 64'd462129831893;
			5: return 64'd2962370717;
			6: return 64'd14106527;
			default: return 64'd51862;
		endcase
	endfunction

	function automatic logic [OUT_W-1:0] predict_trig(logic signed [31:0] angle, trig_op_e op);
		longint      a;
		longint      r;
		longint      m;
		longint      x;
		longint      acc;
		bit          neg;
		logic [63:0] x30;
		logic [63:0] sq;
		logic [63:0] p;
		logic [63:0] term;
		logic [127:0] prod;
		int          n_terms;

		a = angle;
		if (op == OP_COSINE)
			a = a + ANG_HPI;
		r = a % ANG_2PI;
		neg = r < 0;
		m = neg ? -r : r;
		if (m > ANG_3HPI) begin
			x = ANG_2PI - m;
			neg = !neg;
		end else if (m > ANG_PI) begin
			x = m - ANG_PI;
			neg = !neg;
		end else if (m > ANG_HPI) begin
			x = ANG_PI - m;
		end else begin
			x = m;
		end
		if (x < 0)
			x = 0;

		x30 = 64'(x) << 10;
		sq = (x30 * x30) >> 30;
		p = x30;
		acc = longint'(x30);
		n_terms = (SERIES_TERMS < 8) ? SERIES_TERMS : 8;
		for (int i = 0; i < n_terms; i++) begin
			prod = {64'd0, p} * {64'd0, sq};
			p = prod[93:30];
			prod = {64'd0, p} * {64'd0, inv_factorial(i)};
			term = prod[127:64];
			if (i % 2 == 1)
				acc = acc + longint'(term);
			else
				acc = acc - longint'(term);
		end

		if (acc < 0)
			acc = 0;
		if (acc > UNIT_Q30)
			acc = UNIT_Q30;
		if (neg)
			acc = -acc;
		return acc[OUT_W-1:0];
	endfunction

	// entered and left at a falling edge; tvalid stays high if the next word follows at once
	task automatic send_angle(logic signed [31:0] angle, trig_op_e op);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= angle;
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		trig_expected.push_back(predict_trig(angle, op));
		if (op == OP_COSINE)
			cosine_sent++;
		else
			sine_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (trig_expected.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word %h", m_axis_tdata);
			end else begin
				if (m_axis_tdata !== trig_expected[0]) begin
					fail_count++;
					if (fail_count <= 10)
						$display("trig_value mismatch: expected %h got %h",
							trig_expected[0], m_axis_tdata);
				end
				void'(trig_expected.pop_front());
				words_checked++;
			end
		end
	end

	task automatic test_range_extremes();
		send_angle(32'sh8000_0000, OP_SINE);
		send_angle(32'sh8000_0000, OP_COSINE);
		send_angle(32'sh7fff_ffff, OP_SINE);
		send_angle(32'sh7fff_ffff, OP_COSINE);
		send_angle(32'sd0, OP_SINE);
		send_angle(32'sd0, OP_COSINE);
	endtask

	// quadrant edges with alternating signs
	task automatic test_fold_boundaries();
		send_angle(32'(ANG_HPI), OP_SINE);
		send_angle(32'(-(ANG_HPI + 1)), OP_SINE);
		send_angle(32'(ANG_PI), OP_SINE);
		send_angle(32'(-(ANG_PI + 1)), OP_SINE);
		send_angle(32'(ANG_3HPI), OP_SINE);
		send_angle(32'(-(ANG_3HPI + 1)), OP_SINE);
		send_angle(32'(ANG_2PI - 1), OP_SINE);
		send_angle(32'(-ANG_HPI), OP_COSINE);
		send_angle(32'(ANG_3HPI), OP_COSINE);
	endtask

	task automatic test_zero_remainder();
		send_angle(32'(ANG_2PI), OP_SINE);
		send_angle(32'(-ANG_2PI), OP_SINE);
		send_angle(32'(5 * ANG_2PI), OP_SINE);
		send_angle(32'(ANG_2PI - ANG_HPI), OP_COSINE);
	endtask

	task automatic test_random_angles(int count);
		longint           base;
		logic signed [31:0] angle;
		trig_op_e         op;
		int               pick;

		for (int n = 0; n < count; n++) begin
			op = trig_op_e'($urandom_range(0, 1));
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				angle = $urandom();
			end else if (pick < 8) begin
				base = longint'($urandom_range(0, 16 * ANG_2PI)) - 8 * ANG_2PI;
				angle = 32'(base);
			end else begin
				base = longint'($urandom_range(0, 60)) * ANG_HPI
					+ longint'($urandom_range(0, 8)) - 4;
				if ($urandom_range(0, 1))
					base = -base;
				angle = 32'(base);
			end
			send_angle(angle, op);
		end
	endtask

	initial begin
		int waited;

		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		send_idle_pct  = 33;
		sink_stall_pct = 46;
		fail_count     = 0;
		words_checked  = 0;
		sine_sent      = 0;
		cosine_sent    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_range_extremes();
		test_fold_boundaries();
		test_zero_remainder();
		test_random_angles(120);

		send_idle_pct  = 46;
		sink_stall_pct = 33;
		test_random_angles(140);

		send_idle_pct  = 0;
		sink_stall_pct = 0;
		test_random_angles(140);
		stop_sending();

		waited = 0;
		while (trig_expected.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (trig_expected.size() != 0) begin
			fail_count++;
			$display("%0d expected words never arrived", trig_expected.size());
		end

		$display("checked %0d words: %0d sine and %0d cosine angles, with and without stalls",
			words_checked, sine_sent, cosine_sent);
		$display("%0d failures", fail_count);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
